FILE: design/pdrc_pkg.sv
// Shared constants and controller-to-datapath types for the packet deframer.
package pdrc_pkg;

    localparam int MAX_PAYLOAD_DEF = 32;
    localparam logic [7:0] HEADER_RESET = 8'hCC;

    localparam logic [1:0] ST_GOOD = 2'd0;
    localparam logic [1:0] ST_CSUM = 2'd1;
    localparam logic [1:0] ST_OVER = 2'd2;

    typedef struct packed {
        logic cnt_clr;
        logic len_ld;
        logic id_ld;
        logic sum_add;
        logic pay_wr;
        logic sum_clr;
        logic rd_clr;
        logic rd_ld;
        logic rd_inc;
        logic out_single;
        logic out_data;
    } t_dp_cmd;

    typedef struct packed {
        logic hdr_match;
        logic pay_more;
        logic sum_match;
        logic stored_zero;
        logic rd_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: design/pdrc_dp.sv
// Datapath: held fields, checksum, payload memory, drain counter and output register.
module pdrc_dp import pdrc_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic [7:0] i_rx_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [1:0] o_status,
    output logic [7:0] o_packet_id,
    output logic [7:0] o_length_field,
    output logic       o_has_data,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);

    logic [7:0]    r_header;
    logic [7:0]    r_len;
    logic [7:0]    r_id;
    logic [7:0]    r_cnt;
    logic [7:0]    r_sum;
    logic [7:0]    r_mem [MAX_PAYLOAD];
    logic [7:0]    r_rd_data;
    logic [CW-1:0] r_rd_idx;

    logic          r_o_valid;
    logic [1:0]    r_o_status;
    logic [7:0]    r_o_packet_id;
    logic [7:0]    r_o_length_field;
    logic          r_o_has_data;
    logic [5:0]    r_o_byte_index;
    logic [7:0]    r_o_payload_byte;
    logic          r_o_last;

    logic [7:0]    n_sum;
    logic          over;
    logic [CW-1:0] stored;
    logic [1:0]    good_status;

    assign n_sum       = {r_sum[0], r_sum[7:1]} + i_rx_byte;
    assign over        = r_cnt > 8'(MAX_PAYLOAD);
    assign stored      = over ? CW'(MAX_PAYLOAD) : r_cnt[CW-1:0];
    assign good_status = over ? ST_OVER : ST_GOOD;

    assign o_sts.hdr_match   = i_rx_byte == r_header;
    assign o_sts.pay_more    = (r_len != 8'd0) && (r_cnt < r_len - 8'd1);
    assign o_sts.sum_match   = i_rx_byte == r_sum;
    assign o_sts.stored_zero = r_cnt == 8'd0;
    assign o_sts.rd_last     = (r_rd_idx + CW'(1)) == stored;
    assign o_sts.out_free    = !r_o_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header  <= HEADER_RESET;
            r_len     <= 8'd0;
            r_id      <= 8'd0;
            r_cnt     <= 8'd0;
            r_sum     <= 8'd0;
            r_rd_idx  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_header <= i_cfg_wdata;
            end
            if (i_cmd.len_ld) begin
                r_len <= i_rx_byte;
            end
            if (i_cmd.id_ld) begin
                r_id <= i_rx_byte;
            end
            if (i_cmd.cnt_clr) begin
                r_cnt <= 8'd0;
            end else if (i_cmd.pay_wr) begin
                r_cnt <= r_cnt + 8'd1;
            end
            if (i_cmd.sum_clr) begin
                r_sum <= 8'd0;
            end else if (i_cmd.sum_add) begin
                r_sum <= n_sum;
            end
            if (i_cmd.rd_clr) begin
                r_rd_idx <= '0;
            end else if (i_cmd.rd_inc) begin
                r_rd_idx <= r_rd_idx + CW'(1);
            end
            if (i_cmd.out_single || i_cmd.out_data) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pay_wr && (r_cnt < 8'(MAX_PAYLOAD))) begin
            r_mem[r_cnt[AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rd_ld) begin
            r_rd_data <= r_mem[r_rd_idx[AW-1:0]];
        end
        if (i_cmd.out_single) begin
            r_o_status       <= o_sts.sum_match ? good_status : ST_CSUM;
            r_o_packet_id    <= r_id;
            r_o_length_field <= r_len;
            r_o_has_data     <= 1'b0;
            r_o_byte_index   <= 6'd0;
            r_o_payload_byte <= 8'd0;
            r_o_last         <= 1'b1;
        end else if (i_cmd.out_data) begin
            r_o_status       <= good_status;
            r_o_packet_id    <= r_id;
            r_o_length_field <= r_len;
            r_o_has_data     <= 1'b1;
            r_o_byte_index   <= 6'(r_rd_idx);
            r_o_payload_byte <= r_rd_data;
            r_o_last         <= o_sts.rd_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_packet_id    = r_o_packet_id;
    assign o_length_field = r_o_length_field;
    assign o_has_data     = r_o_has_data;
    assign o_byte_index   = r_o_byte_index;
    assign o_payload_byte = r_o_payload_byte;
    assign o_last         = r_o_last;

endmodule

FILE: design/pdrc_ctrl.sv
// Controller: frame phase state machine and result drain sequencing.
module pdrc_ctrl import pdrc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_ID,
        S_PAY,
        S_CHK,
        S_RD,
        S_EMIT,
        S_SWAL
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   acc;

    always_comb begin
        case (r_state)
            S_CHK:         o_stall = !i_sts.out_free;
            S_RD, S_EMIT:  o_stall = 1'b1;
            default:       o_stall = 1'b0;
        endcase
    end

    assign acc = i_valid && !o_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    o_cmd.cnt_clr = 1'b1;
                    if (i_sts.hdr_match) begin
                        n_state = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (acc) begin
                    o_cmd.len_ld = 1'b1;
                    n_state      = S_ID;
                end
            end
            S_ID: begin
                if (acc) begin
                    o_cmd.id_ld   = 1'b1;
                    o_cmd.sum_add = 1'b1;
                    n_state       = S_PAY;
                end
            end
            S_PAY: begin
                if (acc) begin
                    if (i_sts.pay_more) begin
                        o_cmd.pay_wr  = 1'b1;
                        o_cmd.sum_add = 1'b1;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                if (acc) begin
                    o_cmd.sum_clr = 1'b1;
                    if (i_sts.sum_match && !i_sts.stored_zero) begin
                        o_cmd.rd_clr = 1'b1;
                        n_state      = S_RD;
                    end else begin
                        o_cmd.out_single = 1'b1;
                        n_state = i_sts.sum_match ? S_SWAL : S_IDLE;
                    end
                end
            end
            S_RD: begin
                o_cmd.rd_ld = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_data = 1'b1;
                    if (i_sts.rd_last) begin
                        n_state = S_SWAL;
                    end else begin
                        o_cmd.rd_inc = 1'b1;
                        n_state      = S_RD;
                    end
                end
            end
            S_SWAL: begin
                if (acc) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: design/packet_deframer_rotating_checksum_top.sv
// Top level of the serial packet deframer with rotating checksum.
// The block takes one received byte per cycle while it collects a frame (header, length, ID,
// payload, tail, checksum), but the checksum byte waits until the output register is free; a
// single result on a bad checksum or an empty packet is loaded into it as that byte is taken.
// A good packet with payload is replayed from the payload memory by a registered memory read
// and then an output register load per stored byte; the input is stalled for that drain.
module packet_deframer_rotating_checksum_top import pdrc_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_packet_id,
    output logic [7:0] o_length_field,
    output logic       o_has_data,
    output logic [5:0] o_byte_index,
    output logic [7:0] o_payload_byte,
    output logic       o_last
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pdrc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pdrc_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_rx_byte      (i_rx_byte),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_packet_id    (o_packet_id),
        .o_length_field (o_length_field),
        .o_has_data     (o_has_data),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last         (o_last)
    );

endmodule

FILE: test/packet_deframer_rotating_checksum_top_test.sv
// Self-checking testbench for the packet deframer with rotating checksum.
module packet_deframer_rotating_checksum_top_test;
    import pdrc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_SLOTS = MAX_PAYLOAD_DEF;
    localparam int STUCK_LIMIT = 2000;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef enum logic [2:0] {
        RX_IDLE,
        RX_LEN,
        RX_ID,
        RX_PAYLOAD,
        RX_CHECK,
        RX_SWALLOW
    } t_rx_phase;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] packet_id;
        logic [7:0] length_field;
        logic       has_data;
        logic [5:0] byte_index;
        logic [7:0] payload_byte;
        logic       last;
    } t_deframe_beat;

    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        t_deframe_beat want;
    } t_rx_item;

    localparam t_rx_item DIRECTED_ROWS [20] = '{
        '{8'h00, 1'b0, '0},
        '{8'hCC, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{ST_GOOD, 8'hFF, 8'h00, 1'b0, 6'd0, 8'h00, 1'b1}},
        '{8'hCC, 1'b0, '0},
        '{8'hCC, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h01, 1'b1, '{ST_CSUM, 8'h00, 8'h01, 1'b0, 6'd0, 8'h00, 1'b1}},
        '{8'hCC, 1'b0, '0},
        '{8'h03, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h77, 1'b0, '0},
        '{8'h16, 1'b0, '0},
        '{8'h11, 1'b0, '0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [7:0] i_cfg_wdata = 8'h00;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [1:0] o_status;
    logic [7:0] o_packet_id;
    logic [7:0] o_length_field;
    logic       o_has_data;
    logic [5:0] o_byte_index;
    logic [7:0] o_payload_byte;
    logic       o_last;

    t_rx_item      rx_stream[$];
    t_rx_item      cur_item = '0;
    t_deframe_beat expected_beats[$];
    int            planned = 0;
    int            mismatches = 0;
    int            stuck_cycles = 0;
    int            in_gap = 0;
    int            stall_gap = 0;
    int            hold_cnt = 0;
    bit            idling_on = 1'b1;
    bit            hold_phase = 1'b0;
    bit            long_hold_done = 1'b0;

    logic [7:0] hdr_sel = HEADER_RESET;
    t_rx_phase  pr_phase = RX_IDLE;
    logic [7:0] pr_len = 8'h00;
    logic [7:0] pr_id = 8'h00;
    logic [7:0] pr_count = 8'h00;
    logic [7:0] pr_sum = 8'h00;
    logic [7:0] pr_store [PAYLOAD_SLOTS];

    packet_deframer_rotating_checksum_top dut (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] rot_add(input logic [7:0] acc, input logic [7:0] b);
        return {acc[0], acc[7:1]} + b;
    endfunction

    function automatic logic [7:0] other_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == hdr_sel);
        return b;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, input bit emit);
        int         stored;
        logic [1:0] st;
        case (pr_phase)
            RX_LEN: begin
                pr_len = b;
                pr_phase = RX_ID;
            end
            RX_ID: begin
                pr_id = b;
                pr_sum = rot_add(pr_sum, b);
                pr_phase = RX_PAYLOAD;
            end
            RX_PAYLOAD: begin
                if (pr_len >= 8'd1 && int'(pr_count) < int'(pr_len) - 1) begin
                    if (int'(pr_count) < PAYLOAD_SLOTS) begin
                        pr_store[pr_count] = b;
                    end
                    pr_sum = rot_add(pr_sum, b);
                    pr_count = pr_count + 8'd1;
                end else begin
                    pr_phase = RX_CHECK;
                end
            end
            RX_CHECK: begin
                if (b == pr_sum) begin
                    stored = int'(pr_count);
                    st = ST_GOOD;
                    if (stored > PAYLOAD_SLOTS) begin
                        stored = PAYLOAD_SLOTS;
                        st = ST_OVER;
                    end
                    if (emit && stored == 0) begin
                        expected_beats.push_back('{st, pr_id, pr_len, 1'b0, 6'd0, 8'h00, 1'b1});
                    end else if (emit) begin
                        for (int i = 0; i < stored; i++) begin
                            expected_beats.push_back('{st, pr_id, pr_len, 1'b1, 6'(i),
                                                       pr_store[i], 1'(i == stored - 1)});
                        end
                    end
                    pr_phase = RX_SWALLOW;
                end else begin
                    if (emit) begin
                        expected_beats.push_back('{ST_CSUM, pr_id, pr_len, 1'b0, 6'd0,
                                                   8'h00, 1'b1});
                    end
                    pr_phase = RX_IDLE;
                end
                pr_sum = 8'h00;
            end
            RX_SWALLOW: begin
                pr_phase = RX_IDLE;
            end
            default: begin
                pr_count = 8'h00;
                pr_phase = (b == hdr_sel) ? RX_LEN : RX_IDLE;
            end
        endcase
    endtask

    task automatic compare_field(input string field, input logic [7:0] want_v,
                                 input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_deframe_beat want;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t ns: unexpected transaction, expected none, actual %h",
                             $time, {o_status, o_packet_id, o_length_field, o_has_data,
                                     o_byte_index, o_payload_byte, o_last});
                    mismatches++;
                end else begin
                    want = expected_beats.pop_front();
                    compare_field("status", 8'(want.status), 8'(o_status));
                    compare_field("packet_id", want.packet_id, o_packet_id);
                    compare_field("length_field", want.length_field, o_length_field);
                    compare_field("has_data", 8'(want.has_data), 8'(o_has_data));
                    compare_field("byte_index", 8'(want.byte_index), 8'(o_byte_index));
                    compare_field("payload_byte", want.payload_byte, o_payload_byte);
                    compare_field("last", 8'(want.last), 8'(o_last));
                end
            end

            if (i_valid && !o_stall) begin
                deframe_byte(cur_item.rx, !cur_item.typed);
                if (cur_item.typed) begin
                    expected_beats.push_back(cur_item.want);
                end
            end

            if (!i_valid || !o_stall) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_valid <= 1'b0;
                end else if (rx_stream.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (idling_on && $urandom_range(0, 6) == 0) begin
                    in_gap = $urandom_range(0, 9);
                    i_valid <= 1'b0;
                end else begin
                    cur_item = rx_stream.pop_front();
                    i_valid <= 1'b1;
                    i_rx_byte <= cur_item.rx;
                end
            end

            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
                if (stuck_cycles >= STUCK_LIMIT) begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall <= 1'b1;
        end else if (hold_phase && !long_hold_done && o_valid) begin
            hold_cnt = LONG_HOLD_CYCLES - 1;
            long_hold_done = 1'b1;
            i_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            i_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_gap = $urandom_range(0, 9);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        rx_stream.push_back('{b, 1'b0, '0});
        planned++;
    endtask

    task automatic add_packet(input int len_sel, input bit good);
        logic [7:0] sum;
        logic [7:0] b;
        int         n_pay;
        queue_byte(hdr_sel);
        queue_byte(8'(len_sel));
        b = 8'($urandom);
        queue_byte(b);
        sum = rot_add(8'h00, b);
        n_pay = (len_sel >= 1) ? len_sel - 1 : 0;
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom);
            queue_byte(b);
            sum = rot_add(sum, b);
        end
        queue_byte(8'($urandom));
        if (good) begin
            queue_byte(sum);
            queue_byte(($urandom_range(0, 3) == 0) ? hdr_sel : 8'($urandom));
        end else begin
            queue_byte(sum ^ 8'($urandom_range(1, 255)));
        end
    endtask

    task automatic random_packets(input int target);
        int goal;
        int pick;
        int len_sel;
        goal = planned + target;
        while (planned < goal) begin
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 3)) queue_byte(other_byte());
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len_sel = $urandom_range(0, 8);
            end else if (pick < 9) begin
                len_sel = $urandom_range(9, 33);
            end else begin
                len_sel = $urandom_range(34, 45);
            end
            add_packet(len_sel, $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (rx_stream.size() != 0 || i_valid || expected_beats.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic set_header(input logic [7:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        hdr_sel = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED_ROWS[k]) rx_stream.push_back(DIRECTED_ROWS[k]);
        settle();

        set_header(8'h00);
        add_packet(33, 1'b1);
        add_packet(40, 1'b0);
        random_packets(15);
        settle();

        hold_phase = 1'b1;
        set_header(8'hFF);
        random_packets(25);
        settle();

        hold_phase = 1'b0;
        set_header(8'($urandom_range(1, 254)));
        add_packet(255, 1'b1);
        random_packets(10);
        settle();

        idling_on = 1'b0;
        set_header(HEADER_RESET);
        random_packets(20);
        settle();

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
